// ===== sv/fixed_block_pool_allocator_macros.svh =====
// Assertion macros for the fixed block pool allocator.
// Used by the controller and datapath; expects signals named clock and reset.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`ifndef ASSERT_OFF
// Property holds at every clock outside reset
`define FBPA_ASSERT_HOLDS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
// Same-cycle implication
`define FBPA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication
`define FBPA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define FBPA_ASSERT_HOLDS(lbl, expr, msg)
`define FBPA_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define FBPA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/fbpa_pkg.sv =====
// Package for the fixed block pool allocator: sizes, codes, payload and
// control structs. No dependencies.
package fbpa_pkg;

   // Pool geometry (BLOCK_BYTES must be a power of two)
   localparam int NUM_BLOCKS  = 16;
   localparam int BLOCK_BYTES = 8;

   localparam int ADDR_W      = 32;
   localparam int COUNT_W     = 16;
   localparam int FREE_W      = 5;
   localparam int STATUS_W    = 3;
   // link / head width: block index plus a null code equal to NUM_BLOCKS
   localparam int IDX_W       = $clog2(NUM_BLOCKS + 1);
   localparam int BLK_W       = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
   localparam logic [ADDR_W:0] POOL_SPAN = (ADDR_W + 1)'(NUM_BLOCKS * BLOCK_BYTES);

   // Operation codes
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_ALLOCATED = 3'd0,
      STATUS_EXHAUSTED = 3'd1,
      STATUS_MULTI     = 3'd2,
      STATUS_RETURNED  = 3'd3,
      STATUS_NOT_POOL  = 3'd4
   } fbpa_status_type;

   typedef struct packed {
      logic                 func;
      logic [ADDR_W-1:0]    address;
      logic [COUNT_W-1:0]   object_count;
   } fbpa_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]    block_address;
      fbpa_status_type      status;
      logic [FREE_W-1:0]    free_blocks;
   } fbpa_rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic req_ready;
      logic capture;
      logic commit;
   } fbpa_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;
   } fbpa_sts_type;

endpackage

// ===== sv/fbpa_req_if.sv =====
// Request channel interface: valid/ready handshake with request payload.
// Depends on fbpa_pkg.
interface fbpa_req_if;
   import fbpa_pkg::*;

   logic         valid;
   logic         ready;
   fbpa_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/fbpa_rsp_if.sv =====
// Response channel interface: valid/ready handshake with result payload.
// Depends on fbpa_pkg.
interface fbpa_rsp_if;
   import fbpa_pkg::*;

   logic         valid;
   logic         ready;
   fbpa_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/fixed_block_pool_allocator.sv =====
// Fixed block pool allocator: a LIFO free list of NUM_BLOCKS equal blocks of
// BLOCK_BYTES bytes starting at the pool_base register. Each request item gives
// exactly one response item with the block address, a status code and the
// free block count. An item is captured while the head's link is read from
// the link memory into a register, then executed, which loads the output
// register. A response waiting downstream holds the next item in execute.
// The list starts in ascending order straight out of reset; no clearing pass is
// needed. Write pool_base only while no item is in flight.
module fixed_block_pool_allocator (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic [fbpa_pkg::ADDR_W-1:0]  csr_write_data,
   fbpa_req_if.sink                     req_chan,
   fbpa_rsp_if.source                   rsp_chan
);
   import fbpa_pkg::*;

   fbpa_cmd_type cmd;
   fbpa_sts_type sts;

   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   fbpa_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_data       (req_chan.payload),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_data       (rsp_chan.payload),
      .cmd            (cmd),
      .sts            (sts)
   );

   assign req_chan.ready = cmd.req_ready;

endmodule

// ===== sv/fbpa_ctrl.sv =====
// Allocator controller: two-state sequencer, capture then execute.
// Depends on fbpa_pkg and the assertion macro header.
`include "fixed_block_pool_allocator_macros.svh"
module fbpa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  fbpa_pkg::fbpa_sts_type sts,
   output fbpa_pkg::fbpa_cmd_type cmd
);
   import fbpa_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } fbpa_state_type;

   fbpa_state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd.req_ready = 1'b0;
      cmd.capture   = 1'b0;
      cmd.commit    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // wait here while the output register still holds an item
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `FBPA_ASSERT_NEXT(a_accept_starts_exec, req_valid && cmd.req_ready, state_ff == ST_EXEC, "accepted item did not start execution")
   `FBPA_ASSERT_NEXT(a_stall_holds_exec, state_ff == ST_EXEC && !sts.out_free, state_ff == ST_EXEC, "execute left while output stalled")

endmodule

// ===== sv/fbpa_dpath.sv =====
// Allocator datapath: request capture, link memory, free-list head and
// counter, pool range check and output register. Depends on fbpa_pkg and
// the assertion macro header.
`include "fixed_block_pool_allocator_macros.svh"
module fbpa_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic [fbpa_pkg::ADDR_W-1:0]  csr_write_data,
   input  fbpa_pkg::fbpa_req_type       req_data,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output fbpa_pkg::fbpa_rsp_type       rsp_data,
   input  fbpa_pkg::fbpa_cmd_type       cmd,
   output fbpa_pkg::fbpa_sts_type       sts
);
   import fbpa_pkg::*;

   logic [ADDR_W-1:0]     pool_base_ff;
   fbpa_req_type          req_ff;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [IDX_W-1:0]      free_cnt_ff, free_cnt_in;

   // link memory with per-entry valid bits; unwritten entries read as i+1
   logic [IDX_W-1:0]      link_mem [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0] link_valid_ff;
   logic [IDX_W-1:0]      link_rd_ff;
   logic                  link_rd_vld_ff;
   logic [BLK_W-1:0]      link_rd_idx_ff;
   logic [IDX_W-1:0]      head_link;
   logic                  link_we;
   logic [BLK_W-1:0]      link_wa;

   logic [ADDR_W:0]       offset;
   logic                  in_pool;
   logic [BLK_W-1:0]      free_blk;
   logic [ADDR_W-1:0]     alloc_addr;

   logic                  rsp_valid_ff;
   fbpa_rsp_type          rsp_data_ff, rsp_data_in;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff <= '0;
      end else if (csr_write_en) begin
         pool_base_ff <= csr_write_data;
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   // Registered read of the head's link; head is stable from capture on
   always_ff @(posedge clock) begin
      link_rd_ff     <= link_mem[head_ff[BLK_W-1:0]];
      link_rd_vld_ff <= link_valid_ff[head_ff[BLK_W-1:0]];
      link_rd_idx_ff <= head_ff[BLK_W-1:0];
   end

   assign head_link = link_rd_vld_ff ? link_rd_ff
                                     : IDX_W'(link_rd_idx_ff) + IDX_W'(1);

   // Pool range check and containing block
   assign offset     = {1'b0, req_ff.address} - {1'b0, pool_base_ff};
   assign in_pool    = !offset[ADDR_W] && (offset < POOL_SPAN);
   assign free_blk   = offset[BLK_W+BLOCK_SHIFT-1:BLOCK_SHIFT];
   assign alloc_addr = pool_base_ff + (ADDR_W'(head_ff[BLK_W-1:0]) << BLOCK_SHIFT);

   // Execute: decide the outcome and the state update
   always_comb begin
      head_in     = head_ff;
      free_cnt_in = free_cnt_ff;
      link_we     = 1'b0;
      link_wa     = free_blk;
      rsp_data_in.block_address = '0;
      rsp_data_in.status        = STATUS_NOT_POOL;
      if (req_ff.func == FUNC_ALLOC) begin
         if (req_ff.object_count != COUNT_W'(1)) begin
            rsp_data_in.status = STATUS_MULTI;
         end else if (head_ff >= IDX_W'(NUM_BLOCKS)) begin
            rsp_data_in.status = STATUS_EXHAUSTED;
         end else begin
            rsp_data_in.status        = STATUS_ALLOCATED;
            rsp_data_in.block_address = alloc_addr;
            head_in = head_link;
            if (free_cnt_ff != '0) begin
               free_cnt_in = free_cnt_ff - IDX_W'(1);
            end
         end
      end else begin
         if (req_ff.object_count == COUNT_W'(1) && in_pool) begin
            rsp_data_in.status = STATUS_RETURNED;
            link_we = 1'b1;
            head_in = IDX_W'(free_blk);
            if (free_cnt_ff < IDX_W'(NUM_BLOCKS)) begin
               free_cnt_in = free_cnt_ff + IDX_W'(1);
            end
         end
      end
      rsp_data_in.free_blocks = FREE_W'(free_cnt_in);
   end

   // Link memory write
   always_ff @(posedge clock) begin
      if (cmd.commit && link_we) begin
         link_mem[link_wa] <= head_ff;
      end
   end

   // Free-list state
   always_ff @(posedge clock) begin
      if (reset) begin
         link_valid_ff <= '0;
         head_ff       <= '0;
         free_cnt_ff   <= IDX_W'(NUM_BLOCKS);
      end else if (cmd.commit) begin
         if (link_we) begin
            link_valid_ff[link_wa] <= 1'b1;
         end
         head_ff     <= head_in;
         free_cnt_ff <= free_cnt_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   `FBPA_ASSERT_HOLDS(a_free_cnt_range, free_cnt_ff <= IDX_W'(NUM_BLOCKS), "free count above pool size")
   `FBPA_ASSERT_NEXT(a_commit_loads_rsp, cmd.commit, rsp_valid_ff, "committed item not presented")
   `FBPA_ASSERT_IMPLIES(a_addr_only_on_alloc, rsp_valid_ff && rsp_data_ff.status != STATUS_ALLOCATED, rsp_data_ff.block_address == '0, "nonzero address on a fallback item")

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking bench for the fixed block pool allocator: directed corner
// items, then randomized allocate/free traffic over several pool_base values.
// Depends on fbpa_pkg, fbpa_req_if, fbpa_rsp_if and fixed_block_pool_allocator.
module testbench;
   import fbpa_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_ITEMS  = 250;
   localparam int SEGMENT_LEN  = 25;
   localparam int TAIL_CYCLES  = 8;
   localparam int POOL_BYTES   = NUM_BLOCKS * BLOCK_BYTES;
   localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(NUM_BLOCKS);

   // Free-list tracker: mirrors the allocator state and queues expected responses
   class free_list_tracker;
      logic [ADDR_W-1:0] pool_base;
      logic [IDX_W-1:0]  link_of [NUM_BLOCKS];
      logic [IDX_W-1:0]  head_blk;
      logic [FREE_W-1:0] free_cnt;
      fbpa_rsp_type      pending_rsp[$];
      int                errors;
      int                requests;
      int                by_status[5];

      function new();
         for (int i = 0; i < NUM_BLOCKS; i++) link_of[i] = IDX_W'(i + 1);
         head_blk  = '0;
         free_cnt  = FREE_W'(NUM_BLOCKS);
         pool_base = '0;
         errors    = 0;
         requests  = 0;
         foreach (by_status[i]) by_status[i] = 0;
      endfunction

      // Work out the response for one accepted request item
      function void note_request(fbpa_req_type item);
         fbpa_rsp_type      exp_rsp;
         logic [ADDR_W:0]   offset;
         logic [IDX_W-1:0]  blk;
         exp_rsp.block_address = '0;
         if (item.func == FUNC_ALLOC) begin
            if (item.object_count != COUNT_W'(1)) begin
               exp_rsp.status = STATUS_MULTI;
            end else if (head_blk >= NULL_IDX) begin
               exp_rsp.status = STATUS_EXHAUSTED;
            end else begin
               exp_rsp.block_address = pool_base + ADDR_W'(head_blk) * ADDR_W'(BLOCK_BYTES);
               exp_rsp.status = STATUS_ALLOCATED;
               head_blk = link_of[head_blk];
               if (free_cnt > 0) free_cnt--;
            end
         end else begin
            offset = {1'b0, item.address} - {1'b0, pool_base};
            if (item.object_count != COUNT_W'(1) || item.address < pool_base ||
                offset >= (ADDR_W + 1)'(POOL_BYTES)) begin
               exp_rsp.status = STATUS_NOT_POOL;
            end else begin
               blk = IDX_W'(offset / BLOCK_BYTES);
               if (blk >= NULL_IDX) blk = IDX_W'(NUM_BLOCKS - 1);
               link_of[blk] = head_blk;
               head_blk = blk;
               if (free_cnt < FREE_W'(NUM_BLOCKS)) free_cnt++;
               exp_rsp.status = STATUS_RETURNED;
            end
         end
         exp_rsp.free_blocks = free_cnt;
         requests++;
         by_status[int'(exp_rsp.status)]++;
         pending_rsp = {pending_rsp, exp_rsp};
      endfunction

      // Compare one accepted response item with the oldest expectation
      function void check_response(fbpa_rsp_type got);
         fbpa_rsp_type want;
         if (pending_rsp.size() == 0) begin
            $error("response item with no request pending: addr %h status %0d free %0d",
                   got.block_address, got.status, got.free_blocks);
            errors++;
            return;
         end
         want = pending_rsp.pop_front();
         if (got.block_address !== want.block_address) begin
            $error("block_address: expected %h, actual %h", want.block_address,
                   got.block_address);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
         if (got.free_blocks !== want.free_blocks) begin
            $error("free_blocks: expected %0d, actual %0d", want.free_blocks,
                   got.free_blocks);
            errors++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                csr_write_en;
   logic [ADDR_W-1:0]   csr_write_data;
   bit                  steady;
   int                  cycles;
   int                  base_writes;
   free_list_tracker    tracker;

   fbpa_req_if req_if ();
   fbpa_rsp_if rsp_if ();

   fixed_block_pool_allocator u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_chan       (req_if.sink),
      .rsp_chan       (rsp_if.source)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run guard
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic fbpa_req_type make_item(logic func, logic [ADDR_W-1:0] addr,
                                              logic [COUNT_W-1:0] count);
      fbpa_req_type it;
      it.func         = func;
      it.address      = addr;
      it.object_count = count;
      return it;
   endfunction

   // Random item: mostly well-formed allocs and in-pool frees, some noise
   function automatic fbpa_req_type draw_item(int alloc_pct, logic [ADDR_W-1:0] base);
      fbpa_req_type it;
      int           roll;
      roll = $urandom_range(0, 99);
      it.func         = FUNC_ALLOC;
      it.address      = $urandom();
      it.object_count = COUNT_W'(1);
      if (roll < 12) begin
         it.func = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 4))
            0: it.object_count = '0;
            1: it.object_count = '1;
            2: it.object_count = COUNT_W'($urandom_range(2, 65535));
            3: begin
               it.func    = FUNC_FREE;
               it.address = $urandom_range(0, 1) ? base - 1 : base + ADDR_W'(POOL_BYTES);
            end
            default: it.func = FUNC_FREE;
         endcase
      end else if (roll < 12 + (alloc_pct * 88) / 100) begin
         it.func = FUNC_ALLOC;
      end else begin
         it.func    = FUNC_FREE;
         it.address = base + ADDR_W'($urandom_range(0, NUM_BLOCKS - 1) * BLOCK_BYTES);
         if ($urandom_range(0, 1)) it.address += ADDR_W'($urandom_range(0, BLOCK_BYTES - 1));
      end
      return it;
   endfunction

   // Drive one request item; returns at the falling edge after acceptance
   task automatic push_request(fbpa_req_type item);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      tracker.note_request(item);
      @(negedge clock);
   endtask

   // Hold off until every response is back and the block has settled
   task automatic drain_requests();
      req_if.valid <= 1'b0;
      while (tracker.pending_rsp.size() > 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_pool_base(logic [ADDR_W-1:0] value);
      drain_requests();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      tracker.pool_base = value;
      base_writes++;
   endtask

   // Corner items with pool_base at zero
   task automatic run_directed();
      push_request(make_item(FUNC_ALLOC, '1, '0));
      push_request(make_item(FUNC_ALLOC, '0, '1));
      push_request(make_item(FUNC_FREE, '0, '0));
      push_request(make_item(FUNC_FREE, ADDR_W'(POOL_BYTES), COUNT_W'(1)));
      push_request(make_item(FUNC_FREE, '1, COUNT_W'(1)));
      // empty the list, then hit exhaustion and a multi request while empty
      for (int i = 0; i < NUM_BLOCKS; i++)
         push_request(make_item(FUNC_ALLOC, '0, COUNT_W'(1)));
      push_request(make_item(FUNC_ALLOC, '0, COUNT_W'(1)));
      push_request(make_item(FUNC_ALLOC, '0, COUNT_W'(2)));
      // unaligned free inside the last block, twice
      push_request(make_item(FUNC_FREE, ADDR_W'(POOL_BYTES - 1), COUNT_W'(1)));
      push_request(make_item(FUNC_FREE, ADDR_W'(POOL_BYTES - 1), COUNT_W'(1)));
   endtask

   task automatic run_random_phase(int n_items);
      int alloc_pct;
      alloc_pct = 50;
      for (int i = 0; i < n_items; i++) begin
         if (i % SEGMENT_LEN == 0) begin
            steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
               0: alloc_pct = 80;
               1: alloc_pct = 20;
               default: alloc_pct = 50;
            endcase
         end
         push_request(draw_item(alloc_pct, tracker.pool_base));
      end
   endtask

   // Response sink with random back-pressure
   initial begin
      int stall;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         tracker.check_response(rsp_if.payload);
         @(negedge clock);
      end
   end

   // Main sequence
   initial begin
      logic [ADDR_W-1:0] phase_base [6];
      tracker        = new();
      cycles         = 0;
      base_writes    = 0;
      steady         = 1'b0;
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_pool_base('0);
      run_directed();

      phase_base[0] = 32'hFFFF_FFF8;
      phase_base[1] = 32'hFFFF_FFFF;
      phase_base[2] = $urandom();
      phase_base[3] = 32'h0000_1000;
      phase_base[4] = $urandom() & ~ADDR_W'(BLOCK_BYTES - 1);
      phase_base[5] = '0;
      foreach (phase_base[p]) begin
         write_pool_base(phase_base[p]);
         run_random_phase(PHASE_ITEMS);
      end

      drain_requests();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d requests over %0d pool_base writes: %0d allocated, %0d exhausted,",
               tracker.requests, base_writes, tracker.by_status[0], tracker.by_status[1]);
      $display("%0d multi-object, %0d returned, %0d non-pool",
               tracker.by_status[2], tracker.by_status[3], tracker.by_status[4]);
      if (tracker.errors == 0 && tracker.pending_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/fbpa_pkg.sv
sv/fbpa_req_if.sv
sv/fbpa_rsp_if.sv
sv/fbpa_ctrl.sv
sv/fbpa_dpath.sv
sv/fixed_block_pool_allocator.sv
tb/sv/testbench.sv
